// ===== design/pcts_pkg.sv =====
// ----------------------------------------------------------------------------
// pcts_pkg
// Types, constants and helpers shared by the curvature/torsion score unit.
// ----------------------------------------------------------------------------
package pcts_pkg;

    localparam int CW     = 32;          // coordinate width
    localparam int FB     = 16;          // fraction bits of registers and score
    localparam int VW     = CW + 2;      // working vector component width
    localparam int MW     = 33;          // multiplier operand width
    localparam int PW     = 2 * MW;      // multiplier product width
    localparam int UB     = 30;          // unit vectors are Q.30
    localparam int RW     = 32;          // root / quotient width
    localparam int DW     = 64;          // radicand / dividend width
    localparam int REMW   = 36;          // divide/root remainder width
    localparam int ITERS  = 32;          // steps of the divide/root unit
    localparam int ITW    = $clog2(ITERS);
    localparam int CURV_W = FB + 2;
    localparam int TORS_W = FB + 4;
    localparam int SW     = 3;           // points-seen counter width
    localparam int CFG_IW = 8;

    localparam logic [SW-1:0] MAX_SEEN = SW'(4);
    localparam logic [31:0] LAMBDA_ONE = 32'(1) << FB;

    localparam logic [CFG_IW-1:0] REG_LAMBDA  = CFG_IW'(0);
    localparam logic [CFG_IW-1:0] REG_TORSION = CFG_IW'(1);
    localparam logic [CFG_IW-1:0] REG_BETA    = CFG_IW'(2);
    localparam logic [CFG_IW-1:0] REG_EXT     = CFG_IW'(3);

    typedef struct packed {
        logic signed [CW-1:0] coord_x;
        logic signed [CW-1:0] coord_y;
        logic signed [CW-1:0] coord_z;
        logic [31:0]          ext_radius;
        logic                 fiber_start;
    } t_in;

    typedef struct packed {
        logic [31:0] score;
        logic        degenerate;
    } t_out;

    typedef logic signed [VW-1:0] t_comp;
    typedef t_comp [2:0] t_vec;

    typedef struct packed {
        logic [31:0] lambda;
        logic [31:0] tw;
        logic [31:0] beta;
    } t_cfg;

    typedef enum logic {DS_SQRT, DS_DIV} t_ds_op;

    typedef struct packed {
        logic   start;
        t_ds_op op;
    } t_ds_ctl;

    typedef enum logic [4:0] {
        S_IDLE, S_LOAD, S_SHIFT, S_SQ_ISSUE, S_SQ_ACC, S_ROOT_GO, S_ROOT_WAIT,
        S_DIV_GO, S_DIV_WAIT, S_STORE, S_DIFF1, S_DIFF2, S_X_ISSUE, S_X_ACC,
        S_ARG_ISSUE, S_ARG_ACC, S_FROOT_GO, S_FROOT_WAIT, S_LAM_ISSUE,
        S_LAM_ACC, S_DONE
    } t_state;

    typedef enum logic [1:0] {SQ_UNIT, SQ_CURV, SQ_TORS} t_sq_mode;

    function automatic logic [VW-1:0] f_mag(input t_comp v);
        f_mag = v[VW-1] ? VW'(-v) : VW'(v);
    endfunction

endpackage

// ===== design/pcts_mul.sv =====
// ----------------------------------------------------------------------------
// pcts_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module pcts_mul (
    input  logic                   i_clk,
    input  logic [pcts_pkg::MW-1:0] i_a,
    input  logic [pcts_pkg::MW-1:0] i_b,
    output logic [pcts_pkg::PW-1:0] o_p
);
    import pcts_pkg::*;

    logic [PW-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= PW'(i_a) * PW'(i_b);
    end

    assign o_p = r_p;

endmodule

// ===== design/pcts_dsu.sv =====
// ----------------------------------------------------------------------------
// pcts_dsu
// Shared divide / square-root unit, one result bit per cycle.
// ----------------------------------------------------------------------------
module pcts_dsu (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  pcts_pkg::t_ds_ctl         i_ctl,
    input  logic [pcts_pkg::DW-1:0]   i_x,
    input  logic [pcts_pkg::RW-1:0]   i_den,
    output logic                      o_busy,
    output logic [pcts_pkg::RW-1:0]   o_res
);
    import pcts_pkg::*;

    logic            r_busy;
    logic [ITW-1:0]  r_cnt;
    t_ds_op          r_op;
    logic [DW-1:0]   r_x;
    logic [REMW-1:0] r_rem;
    logic [RW-1:0]   r_root;
    logic [RW-1:0]   r_den;

    logic [REMW-1:0] shifted;
    logic [REMW-1:0] trial;
    logic            fit;

    always_comb begin
        if (r_op == DS_SQRT) begin
            shifted = {r_rem[REMW-3:0], r_x[DW-1 -: 2]};
            trial   = REMW'({r_root, 2'b01});
        end else begin
            shifted = {r_rem[REMW-2:0], r_x[DW-1]};
            trial   = REMW'(r_den);
        end
        fit = (shifted >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == ITW'(ITERS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_op   <= i_ctl.op;
            r_den  <= i_den;
            r_root <= '0;
            if (i_ctl.op == DS_SQRT) begin
                r_x   <= i_x;
                r_rem <= '0;
            end else begin
                // quotient fits RW bits, so the upper half seeds the remainder
                r_x   <= {i_x[RW-1:0], {(DW-RW){1'b0}}};
                r_rem <= REMW'(i_x[DW-1:RW]);
            end
        end else if (r_busy) begin
            r_x    <= (r_op == DS_SQRT) ? (r_x << 2) : (r_x << 1);
            r_rem  <= fit ? (shifted - trial) : shifted;
            r_root <= {r_root[RW-2:0], fit};
        end
    end

    assign o_busy = r_busy;
    assign o_res  = r_root;

endmodule

// ===== design/pcts_core.sv =====
// ----------------------------------------------------------------------------
// pcts_core
// Sequencer and datapath: five normalizations, cross product, energy terms
// and final root, all on one multiplier and one divide/root unit.
// ----------------------------------------------------------------------------
module pcts_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  pcts_pkg::t_vec  i_d0,
    input  pcts_pkg::t_vec  i_d1,
    input  pcts_pkg::t_vec  i_d2,
    input  logic [31:0]     i_rad,
    input  pcts_pkg::t_cfg  i_cfg,
    input  logic            i_take,
    output logic            o_busy,
    output logic            o_done,
    output pcts_pkg::t_out  o_res
);
    import pcts_pkg::*;

    t_state   r_state, n_state;
    logic [2:0] r_phase;
    logic [2:0] r_idx;
    t_sq_mode r_mode;

    t_vec r_d0, r_d1, r_d2;
    t_vec r_t0, r_pt0, r_p2t0;
    t_vec r_u;
    logic [2:0][VW-1:0] r_m;
    logic [2:0]         r_neg;
    logic [VW-1:0]      r_top;
    logic [DW-1:0]      r_sum;
    logic [RW-1:0]      r_len;
    logic signed [DW-1:0] r_acc;
    logic               r_xneg;
    logic [2:0][MW-1:0] r_bm;
    logic [CURV_W-1:0]  r_curv;
    logic [TORS_W-1:0]  r_tors;
    logic [DW-1:0]      r_arg;
    logic [RW-1:0]      r_root;
    logic               r_deg;
    logic [31:0]        r_rad;
    t_out               r_res;

    logic [MW-1:0] mul_a, mul_b;
    logic [PW-1:0] prod;
    t_ds_ctl       ds_ctl;
    logic [DW-1:0] ds_x;
    logic          ds_busy;
    logic [RW-1:0] ds_res;

    t_vec               src;
    logic [2:0][VW-1:0] src_mag;
    logic [VW-1:0]      src_top;
    logic [DW-1:0]      sq_sum;
    logic [DW:0]        arg_sum;
    logic signed [DW-1:0] xp;
    logic signed [DW-1:0] xdiff;
    logic [DW-1:0]      xmag;
    logic [DW-FB:0]     score_sum;
    t_comp              q_s;

    pcts_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    pcts_dsu u_dsu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ds_ctl),
        .i_x     (ds_x),
        .i_den   (r_len),
        .o_busy  (ds_busy),
        .o_res   (ds_res)
    );

    // source of the current normalization
    always_comb begin
        case (r_phase)
            3'd1:    src = r_d1;
            3'd2:    src = r_d2;
            3'd3:    src = r_d0;
            3'd4:    src = r_d1;
            default: src = r_d0;
        endcase
        for (int i = 0; i < 3; i++) begin
            src_mag[i] = f_mag(src[i]);
        end
        src_top = src_mag[0];
        if (src_mag[1] > src_top) src_top = src_mag[1];
        if (src_mag[2] > src_top) src_top = src_mag[2];
    end

    always_comb begin
        sq_sum    = r_sum + prod[DW-1:0];
        arg_sum   = {1'b0, r_arg} + {1'b0, prod[DW-1:0]};
        xp        = r_xneg ? -$signed(prod[DW-1:0]) : $signed(prod[DW-1:0]);
        xdiff     = r_acc - xp;
        xmag      = xdiff[DW-1] ? DW'(-xdiff) : DW'(xdiff);
        score_sum = (DW-FB+1)'(prod[DW-1:FB]) + (DW-FB+1)'(r_rad);
        q_s       = r_neg[r_idx[1:0]] ? -$signed(VW'(ds_res)) : $signed(VW'(ds_res));
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:       if (i_start) n_state = S_LOAD;
            S_LOAD:       n_state = (src_top == '0) ? S_STORE : S_SHIFT;
            S_SHIFT: begin
                if (r_top < (VW'(1) << UB) && r_top >= (VW'(1) << (UB - 1))) begin
                    n_state = S_SQ_ISSUE;
                end
            end
            S_SQ_ISSUE:   n_state = S_SQ_ACC;
            S_SQ_ACC: begin
                if (r_idx != 3'd2) begin
                    n_state = S_SQ_ISSUE;
                end else begin
                    case (r_mode)
                        SQ_UNIT: n_state = S_ROOT_GO;
                        SQ_CURV: n_state = S_SQ_ISSUE;
                        default: n_state = S_ARG_ISSUE;
                    endcase
                end
            end
            S_ROOT_GO:    n_state = S_ROOT_WAIT;
            S_ROOT_WAIT:  if (!ds_busy) n_state = S_DIV_GO;
            S_DIV_GO:     n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (!ds_busy) n_state = (r_idx == 3'd2) ? S_STORE : S_DIV_GO;
            end
            S_STORE: begin
                if (r_phase == 3'd2)      n_state = S_DIFF1;
                else if (r_phase == 3'd4) n_state = S_DIFF2;
                else                      n_state = S_LOAD;
            end
            S_DIFF1:      n_state = S_LOAD;
            S_DIFF2:      n_state = S_X_ISSUE;
            S_X_ISSUE:    n_state = S_X_ACC;
            S_X_ACC:      n_state = (r_idx == 3'd5) ? S_SQ_ISSUE : S_X_ISSUE;
            S_ARG_ISSUE:  n_state = S_ARG_ACC;
            S_ARG_ACC:    n_state = (r_idx == 3'd2) ? S_FROOT_GO : S_ARG_ISSUE;
            S_FROOT_GO:   n_state = S_FROOT_WAIT;
            S_FROOT_WAIT: if (!ds_busy) n_state = S_LAM_ISSUE;
            S_LAM_ISSUE:  n_state = S_LAM_ACC;
            S_LAM_ACC:    n_state = S_DONE;
            S_DONE:       if (i_take) n_state = S_IDLE;
            default:      n_state = S_IDLE;
        endcase
    end

    // shared-unit operands and handshake outputs
    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        ds_ctl    = '{start: 1'b0, op: DS_SQRT};
        ds_x      = r_sum;
        unique case (r_state)
            S_SQ_ISSUE: begin
                mul_a = r_m[r_idx[1:0]][MW-1:0];
                mul_b = r_m[r_idx[1:0]][MW-1:0];
            end
            S_X_ISSUE: begin
                // t0 x n1, n1 held in r_d1
                case (r_idx)
                    3'd0: begin mul_a = MW'(f_mag(r_t0[1])); mul_b = MW'(f_mag(r_d1[2])); end
                    3'd1: begin mul_a = MW'(f_mag(r_t0[2])); mul_b = MW'(f_mag(r_d1[1])); end
                    3'd2: begin mul_a = MW'(f_mag(r_t0[2])); mul_b = MW'(f_mag(r_d1[0])); end
                    3'd3: begin mul_a = MW'(f_mag(r_t0[0])); mul_b = MW'(f_mag(r_d1[2])); end
                    3'd4: begin mul_a = MW'(f_mag(r_t0[0])); mul_b = MW'(f_mag(r_d1[1])); end
                    default: begin mul_a = MW'(f_mag(r_t0[1])); mul_b = MW'(f_mag(r_d1[0])); end
                endcase
            end
            S_ARG_ISSUE: begin
                case (r_idx)
                    3'd0:    begin mul_a = MW'(r_curv);      mul_b = MW'(r_curv);      end
                    3'd1:    begin mul_a = MW'(i_cfg.tw);    mul_b = MW'(r_tors);      end
                    default: begin mul_a = MW'(i_cfg.beta);  mul_b = MW'(i_cfg.beta);  end
                endcase
            end
            S_LAM_ISSUE: begin
                mul_a = MW'(i_cfg.lambda);
                mul_b = MW'(r_root);
            end
            S_ROOT_GO: begin
                ds_ctl = '{start: 1'b1, op: DS_SQRT};
                ds_x   = r_sum;
            end
            S_FROOT_GO: begin
                ds_ctl = '{start: 1'b1, op: DS_SQRT};
                ds_x   = r_arg;
            end
            S_DIV_GO: begin
                ds_ctl = '{start: 1'b1, op: DS_DIV};
                ds_x   = DW'(r_m[r_idx[1:0]]) << UB;
            end
            default: ;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);
    assign o_res  = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_d0    <= i_d0;
                r_d1    <= i_d1;
                r_d2    <= i_d2;
                r_rad   <= i_rad;
                r_deg   <= 1'b0;
                r_phase <= '0;
            end
            S_LOAD: begin
                r_m   <= src_mag;
                r_top <= src_top;
                for (int i = 0; i < 3; i++) begin
                    r_neg[i] <= src[i][VW-1];
                end
                if (src_top == '0) begin
                    r_u   <= '0;
                    r_deg <= 1'b1;
                end
                r_idx  <= '0;
                r_sum  <= '0;
                r_mode <= SQ_UNIT;
            end
            S_SHIFT: begin
                if (r_top >= (VW'(1) << UB)) begin
                    r_top <= r_top >> 1;
                    for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] >> 1;
                end else if (r_top < (VW'(1) << (UB - 1))) begin
                    r_top <= r_top << 1;
                    for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] << 1;
                end
            end
            S_SQ_ACC: begin
                if (r_idx != 3'd2) begin
                    r_sum <= sq_sum;
                    r_idx <= r_idx + 1'b1;
                end else begin
                    r_idx <= '0;
                    r_sum <= (r_mode == SQ_UNIT) ? sq_sum : '0;
                    if (r_mode == SQ_CURV) begin
                        r_curv <= sq_sum[DW-1:62-FB];
                        r_mode <= SQ_TORS;
                        for (int i = 0; i < 3; i++) r_m[i] <= VW'(r_bm[i]);
                    end else if (r_mode == SQ_TORS) begin
                        r_tors <= sq_sum[DW-1:60-FB];
                        r_arg  <= '0;
                    end
                end
            end
            S_ROOT_WAIT: begin
                if (!ds_busy) r_len <= ds_res;
            end
            S_DIV_WAIT: begin
                if (!ds_busy) begin
                    r_u[r_idx[1:0]] <= q_s;
                    r_idx <= r_idx + 1'b1;
                end
            end
            S_STORE: begin
                case (r_phase)
                    3'd0:        r_t0   <= r_u;
                    3'd1, 3'd3:  r_pt0  <= r_u;
                    default:     r_p2t0 <= r_u;
                endcase
                r_phase <= r_phase + 1'b1;
            end
            S_DIFF1: begin
                for (int i = 0; i < 3; i++) begin
                    r_d0[i] <= r_t0[i] - r_pt0[i];
                    r_d1[i] <= r_pt0[i] - r_p2t0[i];
                end
            end
            S_DIFF2: begin
                for (int i = 0; i < 3; i++) r_d1[i] <= r_pt0[i] - r_p2t0[i];
                r_idx <= '0;
            end
            S_X_ISSUE: begin
                case (r_idx)
                    3'd0: r_xneg <= r_t0[1][VW-1] ^ r_d1[2][VW-1];
                    3'd1: r_xneg <= r_t0[2][VW-1] ^ r_d1[1][VW-1];
                    3'd2: r_xneg <= r_t0[2][VW-1] ^ r_d1[0][VW-1];
                    3'd3: r_xneg <= r_t0[0][VW-1] ^ r_d1[2][VW-1];
                    3'd4: r_xneg <= r_t0[0][VW-1] ^ r_d1[1][VW-1];
                    default: r_xneg <= r_t0[1][VW-1] ^ r_d1[0][VW-1];
                endcase
            end
            S_X_ACC: begin
                if (!r_idx[0]) begin
                    r_acc <= xp;
                end else begin
                    r_bm[r_idx[2:1]] <= MW'(xmag >> 31);
                end
                if (r_idx == 3'd5) begin
                    // curvature pass over t1, held in r_d0
                    for (int i = 0; i < 3; i++) r_m[i] <= f_mag(r_d0[i]);
                    r_idx  <= '0;
                    r_sum  <= '0;
                    r_mode <= SQ_CURV;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            S_ARG_ACC: begin
                r_arg <= arg_sum[DW] ? '1 : arg_sum[DW-1:0];
                r_idx <= r_idx + 1'b1;
            end
            S_FROOT_WAIT: begin
                if (!ds_busy) r_root <= ds_res;
            end
            S_LAM_ACC: begin
                r_res.score      <= (score_sum[DW-FB:32] != '0) ? '1 : score_sum[31:0];
                r_res.degenerate <= r_deg;
            end
            default: ;
        endcase
    end

    property p_start_idle;
        @(posedge i_clk) disable iff (!i_rst_n) i_start |-> (r_state == S_IDLE);
    endproperty
    a_start_idle: assert property (p_start_idle) else $error("start while busy");

    property p_take_idle;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state == S_DONE && i_take) |=> (r_state == S_IDLE);
    endproperty
    a_take_idle: assert property (p_take_idle) else $error("result taken but not idle");

    property p_shift_nonzero;
        @(posedge i_clk) disable iff (!i_rst_n) (r_state == S_SHIFT) |-> (r_top != '0);
    endproperty
    a_shift_nonzero: assert property (p_shift_nonzero) else $error("shift of zero vector");

    property p_ds_free;
        @(posedge i_clk) disable iff (!i_rst_n) ds_ctl.start |-> !ds_busy;
    endproperty
    a_ds_free: assert property (p_ds_free) else $error("divide/root unit restarted");

endmodule

// ===== design/polyline_curvature_torsion_score_unit.sv =====
// ----------------------------------------------------------------------------
// polyline_curvature_torsion_score_unit
// Curvature/torsion score of fiber points from a discrete Frenet frame.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  in        input      i_in_valid/o_in_stall  i_in_data (t_in)
//  out       output     o_out_valid/i_out_stall o_out_data (t_out)
//  cfg       input      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
//  Points that give no result only update the history and seen count. A scored
//  point runs five normalizations (a shift search, one 32-step root and three
//  32-step divides on the shared divide/root unit; a zero vector skips
//  these), then the cross product, energy terms and final root. Input stalls
//  until the beat moves on. Synchronous active-low reset; config registers
//  return to their defaults. A finished beat waits in the output register
//  while the next point is taken.
// ----------------------------------------------------------------------------
module polyline_curvature_torsion_score_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  pcts_pkg::t_in                 i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output pcts_pkg::t_out                o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pcts_pkg::CFG_IW-1:0]   i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);
    import pcts_pkg::*;

    logic [31:0] r_lambda, r_tw, r_beta;
    logic        r_ext;

    logic signed [CW-1:0] r_hx [3];
    logic signed [CW-1:0] r_hy [3];
    logic signed [CW-1:0] r_hz [3];
    logic [SW-1:0]        r_seen;
    logic [SW-1:0]        seen_eff;

    logic  r_ov;
    t_out  r_out;

    logic  in_acc, start, core_busy, core_done, take;
    t_vec  d0, d1, d2;
    t_cfg  cfg;
    t_out  core_res;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = core_busy;
    assign in_acc      = i_in_valid && !core_busy;
    assign seen_eff    = i_in_data.fiber_start ? '0 : r_seen;
    assign start       = in_acc && (seen_eff >= MAX_SEEN);

    always_comb begin
        d0[0] = VW'(i_in_data.coord_x) - VW'(r_hx[0]);
        d0[1] = VW'(i_in_data.coord_y) - VW'(r_hy[0]);
        d0[2] = VW'(i_in_data.coord_z) - VW'(r_hz[0]);
        d1[0] = VW'(r_hx[0]) - VW'(r_hx[1]);
        d1[1] = VW'(r_hy[0]) - VW'(r_hy[1]);
        d1[2] = VW'(r_hz[0]) - VW'(r_hz[1]);
        d2[0] = VW'(r_hx[1]) - VW'(r_hx[2]);
        d2[1] = VW'(r_hy[1]) - VW'(r_hy[2]);
        d2[2] = VW'(r_hz[1]) - VW'(r_hz[2]);
        cfg.lambda = r_ext ? r_lambda : LAMBDA_ONE;
        cfg.tw     = r_tw;
        cfg.beta   = r_beta;
    end

    pcts_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_d0    (d0),
        .i_d1    (d1),
        .i_d2    (d2),
        .i_rad   (r_ext ? i_in_data.ext_radius : 32'd0),
        .i_cfg   (cfg),
        .i_take  (take),
        .o_busy  (core_busy),
        .o_done  (core_done),
        .o_res   (core_res)
    );

    assign take = core_done && (!r_ov || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lambda <= LAMBDA_ONE;
            r_tw     <= '0;
            r_beta   <= '0;
            r_ext    <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_LAMBDA:  r_lambda <= i_cfg_data;
                REG_TORSION: r_tw     <= i_cfg_data;
                REG_BETA:    r_beta   <= i_cfg_data;
                REG_EXT:     r_ext    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            for (int i = 0; i < 3; i++) begin
                r_hx[i] <= '0;
                r_hy[i] <= '0;
                r_hz[i] <= '0;
            end
        end else if (in_acc) begin
            r_seen <= (seen_eff < MAX_SEEN) ? seen_eff + 1'b1 : seen_eff;
            r_hx[2] <= r_hx[1];
            r_hy[2] <= r_hy[1];
            r_hz[2] <= r_hz[1];
            r_hx[1] <= r_hx[0];
            r_hy[1] <= r_hy[0];
            r_hz[1] <= r_hz[0];
            r_hx[0] <= i_in_data.coord_x;
            r_hy[0] <= i_in_data.coord_y;
            r_hz[0] <= i_in_data.coord_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (take) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) r_out <= core_res;
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

endmodule
